/* rtl/core/pap_pkg.sv */
// shared constants and types of the polygon area and perimeter block
package pap_pkg;

    // polygon size limit
    localparam int MAX_POINTS = 1024;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths
    localparam int COORD_W    = 16;
    localparam int AREA_W     = 42;
    localparam int PERIM_W    = 35;
    localparam int VCOUNT_W   = 11;

    // shoelace term and sum widths
    localparam int PROD_W     = 2 * COORD_W;
    localparam int TERM_W     = PROD_W + 1;
    localparam int CROSS_W    = TERM_W + $clog2(MAX_POINTS);

    // edge length datapath
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int D2_W       = SQ_W + 1;
    localparam int FRAC_SH    = 16;
    localparam int ROOT_W     = (D2_W + FRAC_SH + 1) / 2;
    localparam int SQ_IN_W    = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(SQRT_STEPS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_CLOSED_MODE = REG_IDX_W'(0);

    typedef logic signed [COORD_W-1:0] coord_t;

    // one classified vertex handed from front to back
    typedef struct packed {
        coord_t           prev_x;
        coord_t           prev_y;
        coord_t           cur_x;
        coord_t           cur_y;
        coord_t           first_x;
        coord_t           first_y;
        logic             edge_valid;
        logic             last;
        logic [CNT_W-1:0] count;
        logic             too_many;
    } pap_entry_t;

endpackage

/* rtl/core/pap_ifs.sv */
// valid/ready channel interfaces for vertex beats and result beats

interface pap_vertex_if;
    logic                         valid;
    logic                         ready;
    logic signed [pap_pkg::COORD_W-1:0] x_coord;
    logic signed [pap_pkg::COORD_W-1:0] y_coord;
    logic                         last_point;

    modport source (output valid, output x_coord, output y_coord, output last_point,
                    input ready);
    modport sink   (input valid, input x_coord, input y_coord, input last_point,
                    output ready);
endinterface

interface pap_result_if;
    logic                          valid;
    logic                          ready;
    logic [pap_pkg::AREA_W-1:0]    twice_area;
    logic [pap_pkg::PERIM_W-1:0]   perimeter_q8;
    logic [pap_pkg::VCOUNT_W-1:0]  vertex_count;
    logic                          overflow;

    modport source (output valid, output twice_area, output perimeter_q8,
                    output vertex_count, output overflow, input ready);
    modport sink   (input valid, input twice_area, input perimeter_q8,
                    input vertex_count, input overflow, output ready);
endinterface

/* rtl/core/polygon_area_perimeter_top.sv */
// top level of the polygon area and perimeter block
//
// Vertices arrive on the vertex channel as signed 16-bit x,y beats; last_point
// marks the final vertex of a polygon. One result beat per polygon leaves on the
// result channel: twice the area (exact), the perimeter in Q.8 (sum of floor
// square roots of each edge), the vertex count and an overflow flag. Vertices
// beyond the polygon size limit are dropped and set overflow.
// The front takes one vertex beat per cycle, while the queue has room, into a
// four-entry queue. For each edge the back picks up the entry, multiplies, adds,
// runs the bit-serial square root and accumulates; the last vertex adds the
// closing edge (without the square root if closed_mode is 0) and then loads the
// result register. The back takes no new entry until it is through with the last one.
// The square-root loop sets the sustained rate.
// closed_mode sits at byte address 0 of the APB port and resets to 1.
// Reset clears the polygon state, empties the queue and clears the result valid flag.
// When the result receiver stalls, the finished result waits in its register;
// the back keeps working on the next polygon's edges and the front keeps
// taking vertices until the queue is full.
module polygon_area_perimeter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    pap_vertex_if.sink                      vertex,
    pap_result_if.source                    result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pap_pkg::PADDR_W-1:0]     paddr,
    input  logic [pap_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pap_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic                   closed_mode_reg;
    logic                   reg_hit;
    logic                   fq_valid, fq_ready;
    pap_pkg::pap_entry_t    fq_data;
    logic                   qb_valid, qb_ready;
    pap_pkg::pap_entry_t    qb_data;

    // register port
    assign pready  = 1'b1;
    assign reg_hit = (paddr[pap_pkg::PADDR_W-1:2] == pap_pkg::REG_CLOSED_MODE);
    assign prdata  = reg_hit ? pap_pkg::APB_DATA_W'(closed_mode_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            closed_mode_reg <= pwdata[0];
        end
    end

    // vertex intake
    pap_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vertex),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    // decoupling queue
    pap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // edge engine
    pap_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .closed_mode (closed_mode_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_data      (qb_data),
        .result      (result)
    );

endmodule

/* rtl/core/pap_front.sv */
// vertex intake: tracks first/previous vertex and count, classifies each beat
module pap_front (
    input  logic                clk,
    input  logic                rst_n,
    pap_vertex_if.sink          vertex,
    output logic                q_valid,
    input  logic                q_ready,
    output pap_pkg::pap_entry_t q_data
);

    pap_pkg::coord_t                first_x_reg;
    pap_pkg::coord_t                first_y_reg;
    pap_pkg::coord_t                prev_x_reg;
    pap_pkg::coord_t                prev_y_reg;
    logic [pap_pkg::CNT_W-1:0]      count_reg;
    logic                           too_many_reg;

    logic                           accept;
    logic                           is_first;
    logic                           room;
    pap_pkg::pap_entry_t            entry;

    assign vertex.ready = q_ready;
    assign accept       = vertex.valid && q_ready;

    // classify the incoming vertex
    always_comb
    begin
        is_first         = (count_reg == '0);
        room             = (count_reg < pap_pkg::CNT_W'(pap_pkg::MAX_POINTS));
        entry.prev_x     = is_first ? vertex.x_coord : prev_x_reg;
        entry.prev_y     = is_first ? vertex.y_coord : prev_y_reg;
        entry.first_x    = is_first ? vertex.x_coord : first_x_reg;
        entry.first_y    = is_first ? vertex.y_coord : first_y_reg;
        entry.cur_x      = vertex.x_coord;
        entry.cur_y      = vertex.y_coord;
        entry.edge_valid = !is_first && room;
        entry.last       = vertex.last_point;
        entry.count      = (is_first || room) ? pap_pkg::CNT_W'(count_reg + 1'b1) : count_reg;
        entry.too_many   = too_many_reg || (!is_first && !room);
    end

    // only beats that add an edge or close the polygon go to the back
    assign q_valid = accept && (entry.edge_valid || entry.last);
    assign q_data  = entry;

    // polygon tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg  <= '0;
            first_y_reg  <= '0;
            prev_x_reg   <= '0;
            prev_y_reg   <= '0;
            count_reg    <= '0;
            too_many_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (entry.last)
            begin
                first_x_reg  <= '0;
                first_y_reg  <= '0;
                prev_x_reg   <= '0;
                prev_y_reg   <= '0;
                count_reg    <= '0;
                too_many_reg <= 1'b0;
            end
            else
            begin
                if (is_first)
                begin
                    first_x_reg <= vertex.x_coord;
                    first_y_reg <= vertex.y_coord;
                end
                if (is_first || room)
                begin
                    prev_x_reg <= vertex.x_coord;
                    prev_y_reg <= vertex.y_coord;
                end
                count_reg    <= entry.count;
                too_many_reg <= entry.too_many;
            end
        end
    end

endmodule

/* rtl/core/pap_queue.sv */
// short register queue between the vertex front and the edge back
module pap_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pap_pkg::pap_entry_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pap_pkg::pap_entry_t out_data
);

    pap_pkg::pap_entry_t            slot_reg [pap_pkg::QUEUE_DEPTH];
    logic [pap_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [pap_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [pap_pkg::QCNT_W-1:0]     fill_reg;
    logic [pap_pkg::QCNT_W-1:0]     fill_next;
    logic                           push;
    logic                           pop;

    assign in_ready  = (fill_reg != pap_pkg::QCNT_W'(pap_pkg::QUEUE_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // occupancy
    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = pap_pkg::QCNT_W'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = pap_pkg::QCNT_W'(fill_reg - 1'b1);
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= pap_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= pap_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
            fill_reg <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* rtl/core/pap_back.sv */
// edge engine: shoelace term, bit-serial square root, sums and result register
module pap_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                closed_mode,
    input  logic                q_valid,
    output logic                q_ready,
    input  pap_pkg::pap_entry_t q_data,
    pap_result_if.source        result
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_SQRT = 6'b001000,
        S_ACC  = 6'b010000,
        S_EMIT = 6'b100000
    } back_state_t;

    back_state_t                           state_reg, state_next;
    pap_pkg::pap_entry_t                   ent_reg, ent_next;
    logic                                  close_reg, close_next;
    pap_pkg::coord_t                       ax_reg, ax_next, ay_reg, ay_next;
    pap_pkg::coord_t                       bx_reg, bx_next, by_reg, by_next;
    logic [pap_pkg::SQ_W-1:0]              sqx_reg, sqy_reg;
    logic signed [pap_pkg::PROD_W-1:0]     cxa_reg, cxb_reg;
    logic [pap_pkg::SQ_IN_W-1:0]           v_reg, v_next;
    logic [pap_pkg::REM_W-1:0]             rem_reg, rem_next;
    logic [pap_pkg::ROOT_W-1:0]            root_reg, root_next;
    logic [pap_pkg::STEP_W-1:0]            step_reg, step_next;
    logic signed [pap_pkg::CROSS_W-1:0]    cross_reg, cross_next;
    logic [pap_pkg::PERIM_W-1:0]           len_reg, len_next;

    logic                                  res_valid_reg, res_valid_next;
    logic [pap_pkg::AREA_W-1:0]            area_reg, area_next;
    logic [pap_pkg::PERIM_W-1:0]           perim_reg, perim_next;
    logic [pap_pkg::VCOUNT_W-1:0]          vcount_reg, vcount_next;
    logic                                  ovf_reg, ovf_next;

    logic signed [pap_pkg::DIFF_W-1:0]     dx, dy;
    logic signed [2*pap_pkg::DIFF_W-1:0]   dx_sq, dy_sq;
    logic signed [pap_pkg::PROD_W-1:0]     prod_a, prod_b;
    logic signed [pap_pkg::TERM_W-1:0]     term;
    logic [pap_pkg::D2_W-1:0]              d2;
    logic [pap_pkg::REM_W-1:0]             rem_sh, trial;
    logic                                  ge;
    logic [pap_pkg::CROSS_W-1:0]           area_abs;
    logic                                  out_free;

    // multiplier inputs, one product per register
    assign dx     = {ax_reg[pap_pkg::COORD_W-1], ax_reg} - {bx_reg[pap_pkg::COORD_W-1], bx_reg};
    assign dy     = {ay_reg[pap_pkg::COORD_W-1], ay_reg} - {by_reg[pap_pkg::COORD_W-1], by_reg};
    assign dx_sq  = dx * dx;
    assign dy_sq  = dy * dy;
    assign prod_a = ax_reg * by_reg;
    assign prod_b = ay_reg * bx_reg;

    // shoelace term and squared length
    assign term = {cxa_reg[pap_pkg::PROD_W-1], cxa_reg} - {cxb_reg[pap_pkg::PROD_W-1], cxb_reg};
    assign d2   = pap_pkg::D2_W'(sqx_reg) + pap_pkg::D2_W'(sqy_reg);

    // one root digit per cycle
    assign rem_sh = {rem_reg[pap_pkg::REM_W-3:0], v_reg[pap_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {1'b0, root_reg[pap_pkg::ROOT_W-2:0], 2'b01};
    assign ge     = (rem_sh >= trial);

    // magnitude of the closed shoelace sum
    assign area_abs = cross_reg[pap_pkg::CROSS_W-1] ? pap_pkg::CROSS_W'(-cross_reg)
                                                    : pap_pkg::CROSS_W'(cross_reg);

    assign out_free     = !res_valid_reg || result.ready;
    assign q_ready      = (state_reg == S_IDLE);
    assign result.valid        = res_valid_reg;
    assign result.twice_area   = area_reg;
    assign result.perimeter_q8 = perim_reg;
    assign result.vertex_count = vcount_reg;
    assign result.overflow     = ovf_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        close_next     = close_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        v_next         = v_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        step_next      = step_reg;
        cross_next     = cross_reg;
        len_next       = len_reg;
        res_valid_next = res_valid_reg && !result.ready;
        area_next      = area_reg;
        perim_next     = perim_reg;
        vcount_next    = vcount_reg;
        ovf_next       = ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    ent_next = q_data;
                    ax_next  = q_data.prev_x;
                    ay_next  = q_data.prev_y;
                    if (q_data.edge_valid)
                    begin
                        bx_next    = q_data.cur_x;
                        by_next    = q_data.cur_y;
                        close_next = 1'b0;
                        state_next = S_MUL;
                    end
                    else if (q_data.last)
                    begin
                        bx_next    = q_data.first_x;
                        by_next    = q_data.first_y;
                        close_next = 1'b1;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cross_next = cross_reg + {{(pap_pkg::CROSS_W - pap_pkg::TERM_W){term[pap_pkg::TERM_W-1]}}, term};
                v_next     = pap_pkg::SQ_IN_W'({d2, {pap_pkg::FRAC_SH{1'b0}}});
                rem_next   = '0;
                root_next  = '0;
                step_next  = '0;
                if (close_reg && !closed_mode)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                rem_next  = ge ? pap_pkg::REM_W'(rem_sh - trial) : rem_sh;
                root_next = {root_reg[pap_pkg::ROOT_W-2:0], ge};
                v_next    = v_reg << 2;
                step_next = pap_pkg::STEP_W'(step_reg + 1'b1);
                if (step_reg == pap_pkg::STEP_W'(pap_pkg::SQRT_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                len_next = len_reg + pap_pkg::PERIM_W'(root_reg);
                if (!close_reg && ent_reg.last)
                begin
                    ax_next    = ent_reg.cur_x;
                    ay_next    = ent_reg.cur_y;
                    bx_next    = ent_reg.first_x;
                    by_next    = ent_reg.first_y;
                    close_next = 1'b1;
                    state_next = S_MUL;
                end
                else if (close_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    area_next      = pap_pkg::AREA_W'(area_abs);
                    perim_next     = len_reg;
                    vcount_next    = pap_pkg::VCOUNT_W'(ent_reg.count);
                    ovf_next       = ent_reg.too_many;
                    cross_next     = '0;
                    len_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            close_reg     <= 1'b0;
            step_reg      <= '0;
            cross_reg     <= '0;
            len_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            close_reg     <= close_next;
            step_reg      <= step_next;
            cross_reg     <= cross_next;
            len_reg       <= len_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        sqx_reg    <= dx_sq[pap_pkg::SQ_W-1:0];
        sqy_reg    <= dy_sq[pap_pkg::SQ_W-1:0];
        cxa_reg    <= prod_a;
        cxb_reg    <= prod_b;
        v_reg      <= v_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        area_reg   <= area_next;
        perim_reg  <= perim_next;
        vcount_reg <= vcount_next;
        ovf_reg    <= ovf_next;
    end

endmodule

/* rtl/core/pap_checker.sv */
// port-level checks of the polygon area and perimeter block, bound to the top
module pap_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  logic [pap_pkg::AREA_W-1:0]      twice_area,
    input  logic [pap_pkg::PERIM_W-1:0]     perimeter_q8,
    input  logic [pap_pkg::VCOUNT_W-1:0]    vertex_count,
    input  logic                            overflow,
    input  logic                            pready
);

    // a stalled result beat holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(twice_area)
            && $stable(perimeter_q8) && $stable(vertex_count) && $stable(overflow)))
        else $error("result beat changed while stalled");

    // every polygon has at least one vertex and never more than the limit
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (vertex_count != '0
            && vertex_count <= pap_pkg::VCOUNT_W'(pap_pkg::MAX_POINTS)))
        else $error("vertex count out of range");

    // overflow only once the polygon is full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && overflow) |-> (vertex_count == pap_pkg::VCOUNT_W'(pap_pkg::MAX_POINTS)))
        else $error("overflow with a partial polygon");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind polygon_area_perimeter_top pap_checker u_pap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .twice_area   (result.twice_area),
    .perimeter_q8 (result.perimeter_q8),
    .vertex_count (result.vertex_count),
    .overflow     (result.overflow),
    .pready       (pready)
);

/* tb/sv/polygon_area_perimeter_top_tb.sv */
// self-checking testbench for the polygon area and perimeter block
module polygon_area_perimeter_top_tb;
    import pap_pkg::*;

    localparam int TIMEOUT_CYCLES = 800000;
    localparam int RANDOM_ITEMS   = 80;
    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 2500;

    // one expected result beat
    typedef struct packed {
        logic [AREA_W-1:0]   twice_area;
        logic [PERIM_W-1:0]  perimeter_q8;
        logic [VCOUNT_W-1:0] vertex_count;
        logic                overflow;
    } poly_result_t;

    typedef enum int {COORD_FULL, COORD_NEAR, COORD_EDGE} coord_style_e;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pap_vertex_if vtx_if ();
    pap_result_if res_if ();

    polygon_area_perimeter_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vtx_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // expected polygon results, oldest first
    poly_result_t pending_results[$];
    int           error_count = 0;

    // mirror of the block's polygon state and mode
    bit                  closed_mode_q = 1'b1;
    coord_t              first_x_q = '0;
    coord_t              first_y_q = '0;
    coord_t              prev_x_q = '0;
    coord_t              prev_y_q = '0;
    longint              cross_sum_q = 0;
    longint unsigned     length_sum_q = 0;
    int                  count_q = 0;
    bit                  too_many_q = 1'b0;

    // sender and receiver pacing
    bit       vtx_on = 1'b0;
    int       burst_left = 0;
    logic     rx_hold = 1'b0;
    rx_mode_e rx_mode = RX_OPEN;
    int       rx_left = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_CYCLES * 20);
        $display("== FAIL ==");
        $finish;
    end

    // floor of edge length times 256, bit-by-bit square root of d2 << 16
    function automatic longint unsigned edge_length_q8(coord_t ax, coord_t ay,
                                                       coord_t bx, coord_t by);
        longint          dx;
        longint          dy;
        longint unsigned v;
        longint unsigned root;
        longint unsigned probe;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        v = longint'(dx * dx + dy * dy) << 16;
        root = 0;
        probe = 64'h1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v -= root + probe;
                root = (root >> 1) + probe;
            end
            else
            begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // shoelace and perimeter update for one accepted vertex
    function automatic void track_vertex(coord_t x, coord_t y, logic last);
        poly_result_t    r;
        longint unsigned perim;
        longint          area;
        if (count_q == 0)
        begin
            first_x_q = x;
            first_y_q = y;
            prev_x_q  = x;
            prev_y_q  = y;
            count_q   = 1;
        end
        else if (count_q < MAX_POINTS)
        begin
            cross_sum_q += longint'(prev_x_q) * longint'(y) - longint'(prev_y_q) * longint'(x);
            length_sum_q += edge_length_q8(prev_x_q, prev_y_q, x, y);
            prev_x_q = x;
            prev_y_q = y;
            count_q++;
        end
        else
        begin
            // vertex beyond the limit is dropped
            too_many_q = 1'b1;
        end

        if (last)
        begin
            // close back to the first vertex
            cross_sum_q += longint'(prev_x_q) * longint'(first_y_q)
                         - longint'(prev_y_q) * longint'(first_x_q);
            area  = (cross_sum_q < 0) ? -cross_sum_q : cross_sum_q;
            perim = length_sum_q;
            if (closed_mode_q)
                perim += edge_length_q8(prev_x_q, prev_y_q, first_x_q, first_y_q);
            r.twice_area   = AREA_W'(area);
            r.perimeter_q8 = PERIM_W'(perim);
            r.vertex_count = VCOUNT_W'(count_q);
            r.overflow     = too_many_q;
            pending_results.insert(pending_results.size(), r);
            first_x_q    = '0;
            first_y_q    = '0;
            prev_x_q     = '0;
            prev_y_q     = '0;
            cross_sum_q  = 0;
            length_sum_q = 0;
            count_q      = 0;
            too_many_q   = 1'b0;
        end
    endfunction

    function automatic void log_mismatch(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endfunction

    function automatic coord_t pick_coord(coord_style_e style);
        case (style)
            COORD_NEAR: return coord_t'(int'($urandom_range(0, 32)) - 16);
            COORD_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0:       return coord_t'(-32768);
                    1:       return coord_t'(32767);
                    2:       return coord_t'(-1);
                    3:       return coord_t'(0);
                    default: return coord_t'(1);
                endcase
            end
            default:    return coord_t'($urandom);
        endcase
    endfunction

    // one vertex beat, then burst or gap bookkeeping
    task automatic send_vertex(coord_t x, coord_t y, logic last);
        int gap;
        if (!vtx_on)
        begin
            vtx_if.valid <= 1'b1;
            vtx_on = 1'b1;
        end
        vtx_if.x_coord    <= x;
        vtx_if.y_coord    <= y;
        vtx_if.last_point <= last;
        @(posedge clk);
        while (!vtx_if.ready)
            @(posedge clk);
        track_vertex(x, y, last);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            vtx_if.valid <= 1'b0;
            vtx_on = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70)
                                               : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 7);
        end
    endtask

    task automatic send_random_polygon(int n, coord_style_e style);
        for (int i = 0; i < n; i++)
            send_vertex(pick_coord(style), pick_coord(style), i == n - 1);
    endtask

    // stop offering vertices and let every expected result arrive
    task automatic wait_for_results(int settle);
        int guard;
        if (vtx_on)
        begin
            vtx_if.valid <= 1'b0;
            vtx_on = 1'b0;
        end
        guard = 0;
        while (pending_results.size() != 0 && guard < 400000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (settle) @(posedge clk);
    endtask

    // apb setup and access phases on the mode register
    task automatic apb_access(input logic wr, input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'({REG_CLOSED_MODE, 2'b00});
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_closed_mode(bit mode);
        logic [APB_DATA_W-1:0] rd;
        wait_for_results(SETTLE_CYCLES);
        apb_access(1'b1, APB_DATA_W'(mode), rd);
        closed_mode_q = mode;
        apb_access(1'b0, '0, rd);
        if (rd[0] !== mode)
            log_mismatch($sformatf("closed_mode readback: expected %0d actual %0b",
                                   mode, rd[0]));
    endtask

    // single vertices, extreme coordinates, degenerate shapes, reset mode
    task automatic test_directed_shapes();
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd1, 16'sd0, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b0);
        send_vertex(16'sd0, 16'sd1, 1'b1);
        send_vertex(16'sd5, -16'sd7, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        send_vertex(16'sd100, 16'sd100, 1'b0);
        send_vertex(16'sd100, 16'sd100, 1'b0);
        send_vertex(-16'sd1, -16'sd1, 1'b1);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd1, 16'sd0, 1'b1);
    endtask

    // polygon past the size limit, ending on a dropped vertex
    task automatic test_vertex_limit();
        write_closed_mode(1'b1);
        send_random_polygon(MAX_POINTS + 2, COORD_FULL);
    endtask

    // receiver held off while triangles keep coming, so the input stalls
    task automatic test_result_backpressure();
        write_closed_mode(1'b1);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (12) send_random_polygon(3, COORD_FULL);
            end
        join
    endtask

    // random polygons in phases that alternate the mode
    task automatic test_random_polygons();
        int           sent;
        int           n;
        int           pick;
        coord_style_e style;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_closed_mode(phase % 2);
            sent = 0;
            while (sent < RANDOM_ITEMS / 4)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8);
                pick = $urandom_range(0, 9);
                style = (pick < 6) ? COORD_FULL : (pick < 8) ? COORD_NEAR : COORD_EDGE;
                send_random_polygon(n, style);
                sent += n;
            end
        end
    endtask

    // result receiver with a changing stall pattern
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            if (rx_hold)
                res_if.ready <= 1'b0;
            else
            begin
                case (rx_mode)
                    RX_OPEN:   res_if.ready <= 1'b1;
                    RX_COIN:   res_if.ready <= $urandom_range(0, 1);
                    RX_SPARSE: res_if.ready <= ($urandom_range(0, 9) == 0);
                    default:   res_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        poly_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
                log_mismatch($sformatf(
                    "unexpected result beat: area %0d perim %0d count %0d ovf %0b",
                    res_if.twice_area, res_if.perimeter_q8, res_if.vertex_count,
                    res_if.overflow));
            else
            begin
                want = pending_results.pop_front();
                if (res_if.twice_area !== want.twice_area ||
                    res_if.perimeter_q8 !== want.perimeter_q8 ||
                    res_if.vertex_count !== want.vertex_count ||
                    res_if.overflow !== want.overflow)
                    log_mismatch($sformatf({
                        "result mismatch: expected area %0d perim %0d count %0d ovf %0b,",
                        " actual area %0d perim %0d count %0d ovf %0b"},
                        want.twice_area, want.perimeter_q8, want.vertex_count, want.overflow,
                        res_if.twice_area, res_if.perimeter_q8, res_if.vertex_count,
                        res_if.overflow));
            end
        end
    end

    // reset, test sequence and verdict
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        vtx_if.valid      = 1'b0;
        vtx_if.x_coord    = '0;
        vtx_if.y_coord    = '0;
        vtx_if.last_point = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_shapes();
        test_vertex_limit();
        test_result_backpressure();
        test_random_polygons();

        wait_for_results(SETTLE_CYCLES);
        if (error_count == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/pap_pkg.sv
rtl/core/pap_ifs.sv
rtl/core/pap_front.sv
rtl/core/pap_queue.sv
rtl/core/pap_back.sv
rtl/core/polygon_area_perimeter_top.sv
rtl/core/pap_checker.sv
tb/sv/polygon_area_perimeter_top_tb.sv
